// ===== hdl/rgb_matrix_frame_buffer_core_macros.svh =====
// assertion macros for the rgb matrix frame buffer checker
`ifndef RGB_MATRIX_FRAME_BUFFER_CORE_MACROS_SVH
`define RGB_MATRIX_FRAME_BUFFER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define RMFB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RMFB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rmfb_pkg.sv =====
// shared types and constants for the rgb matrix frame buffer
package rmfb_pkg;

    localparam int MATRIX_SIZE = 8;
    localparam int COL_W       = $clog2(MATRIX_SIZE);
    localparam int IN_DATA_W   = 24;
    localparam int OUT_DATA_W  = 40;
    localparam int CMD_W       = 3;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(MATRIX_SIZE - 1);
    localparam logic [7:0]       COL0_SEL = 8'h80;

    localparam logic RESULT_PIXEL = 1'b0;
    localparam logic RESULT_FRAME = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_FILL_BOX    = 3'd0,
        CMD_FILL_SCREEN = 3'd1,
        CMD_INVERT      = 3'd2,
        CMD_ROTATE      = 3'd3,
        CMD_READ_PIXEL  = 3'd4,
        CMD_REFRESH     = 3'd5
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_BOX,
        ST_REFRESH
    } state_t;

    typedef logic [MATRIX_SIZE-1:0][7:0] plane_t;

    // controller to datapath
    typedef struct packed {
        logic             load;
        logic             box_write;
        logic             fill_all;
        logic             invert_all;
        logic             rotate_all;
        logic             emit_pixel;
        logic             emit_frame;
        logic [COL_W-1:0] col;
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [COL_W-1:0] x_lo;
        logic [COL_W-1:0] x_hi;
        logic             angle_nz;
        logic             out_free;
    } dp_stat_t;

endpackage

// ===== hdl/rmfb_ctrl.sv =====
// command sequencer: decodes the latched command and steps the column counter
module rmfb_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    output rmfb_pkg::dp_cmd_t  dp_cmd,
    input  rmfb_pkg::dp_stat_t dp_stat
);

    rmfb_pkg::state_t               state_reg;
    rmfb_pkg::state_t               state_next;
    logic [rmfb_pkg::COL_W-1:0]     col_reg;
    logic [rmfb_pkg::COL_W-1:0]     col_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmfb_pkg::ST_IDLE;
            col_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        s_tready   = 1'b0;
        dp_cmd     = '0;
        dp_cmd.col = col_reg;

        case (state_reg)
            rmfb_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    dp_cmd.load = 1'b1;
                    state_next  = rmfb_pkg::ST_EXEC;
                end
            end

            rmfb_pkg::ST_EXEC:
            begin
                state_next = rmfb_pkg::ST_IDLE;
                case (rmfb_pkg::cmd_t'(dp_stat.cmd))
                    rmfb_pkg::CMD_FILL_BOX:
                    begin
                        col_next   = dp_stat.x_lo;
                        state_next = rmfb_pkg::ST_BOX;
                    end
                    rmfb_pkg::CMD_FILL_SCREEN: dp_cmd.fill_all   = 1'b1;
                    rmfb_pkg::CMD_INVERT:      dp_cmd.invert_all = 1'b1;
                    rmfb_pkg::CMD_ROTATE:      dp_cmd.rotate_all = dp_stat.angle_nz;
                    rmfb_pkg::CMD_READ_PIXEL:
                    begin
                        // hold here until the output word slot frees up
                        if (dp_stat.out_free)
                            dp_cmd.emit_pixel = 1'b1;
                        else
                            state_next = rmfb_pkg::ST_EXEC;
                    end
                    rmfb_pkg::CMD_REFRESH:
                    begin
                        col_next   = '0;
                        state_next = rmfb_pkg::ST_REFRESH;
                    end
                    default: state_next = rmfb_pkg::ST_IDLE;
                endcase
            end

            rmfb_pkg::ST_BOX:
            begin
                dp_cmd.box_write = 1'b1;
                if (col_reg == dp_stat.x_hi)
                    state_next = rmfb_pkg::ST_IDLE;
                else
                    col_next = col_reg + 1'b1;
            end

            rmfb_pkg::ST_REFRESH:
            begin
                if (dp_stat.out_free)
                begin
                    dp_cmd.emit_frame = 1'b1;
                    if (col_reg == rmfb_pkg::COL_LAST)
                        state_next = rmfb_pkg::ST_IDLE;
                    else
                        col_next = col_reg + 1'b1;
                end
            end

            default: state_next = rmfb_pkg::ST_IDLE;
        endcase
    end

endmodule

// ===== hdl/rmfb_datapath.sv =====
// bit planes, input word latch, column update logic and output register
module rmfb_datapath
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [rmfb_pkg::IN_DATA_W-1:0]    s_tdata,
    input  logic [rmfb_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [rmfb_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast,
    input  rmfb_pkg::dp_cmd_t                 dp_cmd,
    output rmfb_pkg::dp_stat_t                dp_stat
);

    // latched input word
    logic [rmfb_pkg::CMD_W-1:0] cmd_reg;
    logic [2:0]                 x0_reg;
    logic [2:0]                 y0_reg;
    logic [2:0]                 x1_reg;
    logic [2:0]                 y1_reg;
    logic [3:0]                 colour_reg;
    logic [1:0]                 angle_reg;

    rmfb_pkg::plane_t red_reg, red_next;
    rmfb_pkg::plane_t green_reg, green_next;
    rmfb_pkg::plane_t blue_reg, blue_next;
    rmfb_pkg::plane_t bar_reg, bar_next;

    logic                                m_valid_reg;
    logic [rmfb_pkg::OUT_DATA_W-1:0]     m_data_reg;
    logic [rmfb_pkg::OUT_DATA_W-1:0]     m_data_next;
    logic                                m_user_reg;
    logic                                m_last_reg;

    logic [2:0] y_lo;
    logic [2:0] y_hi;
    logic [7:0] row_mask;
    logic [3:0] pixel_bits;
    logic       out_free;

    function automatic rmfb_pkg::plane_t rot_plane(rmfb_pkg::plane_t p, logic [1:0] a);
        rmfb_pkg::plane_t r;
        r = '0;
        for (int i = 0; i < rmfb_pkg::MATRIX_SIZE; i++)
        begin
            for (int j = 0; j < rmfb_pkg::MATRIX_SIZE; j++)
            begin
                case (a)
                    2'd1:    r[i][j] = p[j][rmfb_pkg::MATRIX_SIZE-1-i];
                    2'd2:    r[i][j] = p[rmfb_pkg::MATRIX_SIZE-1-i][rmfb_pkg::MATRIX_SIZE-1-j];
                    2'd3:    r[i][j] = p[rmfb_pkg::MATRIX_SIZE-1-j][i];
                    default: r[i][j] = p[i][j];
                endcase
            end
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (dp_cmd.load)
        begin
            cmd_reg    <= s_tuser;
            x0_reg     <= s_tdata[2:0];
            y0_reg     <= s_tdata[5:3];
            x1_reg     <= s_tdata[8:6];
            y1_reg     <= s_tdata[11:9];
            colour_reg <= s_tdata[15:12];
            angle_reg  <= s_tdata[17:16];
        end
    end

    assign y_lo = (y1_reg < y0_reg) ? y1_reg : y0_reg;
    assign y_hi = (y1_reg < y0_reg) ? y0_reg : y1_reg;

    always_comb
    begin
        for (int j = 0; j < 8; j++)
            row_mask[j] = (3'(j) >= y_lo) && (3'(j) <= y_hi);
    end

    always_comb
    begin
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        bar_next   = bar_reg;
        if (dp_cmd.box_write)
        begin
            red_next[dp_cmd.col]   = (red_reg[dp_cmd.col] & ~row_mask)
                                   | (colour_reg[0] ? row_mask : 8'h00);
            green_next[dp_cmd.col] = (green_reg[dp_cmd.col] & ~row_mask)
                                   | (colour_reg[1] ? row_mask : 8'h00);
            blue_next[dp_cmd.col]  = (blue_reg[dp_cmd.col] & ~row_mask)
                                   | (colour_reg[2] ? row_mask : 8'h00);
            bar_next[dp_cmd.col]   = (bar_reg[dp_cmd.col] & ~row_mask)
                                   | (colour_reg[3] ? row_mask : 8'h00);
        end
        else if (dp_cmd.fill_all)
        begin
            red_next   = {rmfb_pkg::MATRIX_SIZE{{8{colour_reg[0]}}}};
            green_next = {rmfb_pkg::MATRIX_SIZE{{8{colour_reg[1]}}}};
            blue_next  = {rmfb_pkg::MATRIX_SIZE{{8{colour_reg[2]}}}};
            bar_next   = {rmfb_pkg::MATRIX_SIZE{{8{colour_reg[3]}}}};
        end
        else if (dp_cmd.invert_all)
        begin
            red_next   = ~red_reg;
            green_next = ~green_reg;
            blue_next  = ~blue_reg;
        end
        else if (dp_cmd.rotate_all)
        begin
            red_next   = rot_plane(red_reg, angle_reg);
            green_next = rot_plane(green_reg, angle_reg);
            blue_next  = rot_plane(blue_reg, angle_reg);
            bar_next   = rot_plane(bar_reg, angle_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            red_reg   <= '0;
            green_reg <= '0;
            blue_reg  <= '0;
            bar_reg   <= '0;
        end
        else
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
            bar_reg   <= bar_next;
        end
    end

    assign pixel_bits = {bar_reg[x0_reg][y0_reg], blue_reg[x0_reg][y0_reg],
                         green_reg[x0_reg][y0_reg], red_reg[x0_reg][y0_reg]};

    // word layout: pixel, column select, blue, red, green, zero pad
    always_comb
    begin
        if (dp_cmd.emit_frame)
            m_data_next = {4'h0, ~green_reg[dp_cmd.col], ~red_reg[dp_cmd.col],
                           ~blue_reg[dp_cmd.col], rmfb_pkg::COL0_SEL >> dp_cmd.col, 4'h0};
        else
            m_data_next = {36'h0, pixel_bits};
    end

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (dp_cmd.emit_pixel || dp_cmd.emit_frame)
            m_valid_reg <= 1'b1;
        else if (m_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (dp_cmd.emit_pixel || dp_cmd.emit_frame)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= dp_cmd.emit_frame ? rmfb_pkg::RESULT_FRAME : rmfb_pkg::RESULT_PIXEL;
            m_last_reg <= dp_cmd.emit_frame && (dp_cmd.col == rmfb_pkg::COL_LAST);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    assign dp_stat.cmd      = cmd_reg;
    assign dp_stat.x_lo     = (x1_reg < x0_reg) ? x1_reg : x0_reg;
    assign dp_stat.x_hi     = (x1_reg < x0_reg) ? x0_reg : x1_reg;
    assign dp_stat.angle_nz = (angle_reg != 2'd0);
    assign dp_stat.out_free = out_free;

endmodule

// ===== hdl/rgb_matrix_frame_buffer_core.sv =====
// top level of the 8x8 rgb matrix frame buffer
//
//  channel   | direction | tdata                                  | tuser       | tlast
//  s_*       | in        | x_first y_first x_second y_second      | cmd         | -
//            |           | pixel_value angle (24 bits)            |             |
//  m_*       | out       | pixel_read column_select blue_drive    | result_kind | last_column
//            |           | red_drive green_drive (40 bits)        |             |
//
// one command at a time: a word is taken only while the sequencer is idle
// fill screen, invert, rotate, unused codes: accept, then execute; read pixel: execute waits for a free output
// fill box: accept, execute, then one box write per column of the box, stepped by the column counter
// refresh: accept, execute, then one column frame per column (8), each waiting on a free output register
// reset clears all four planes at once; the output register holds a word until m_tready
module rgb_matrix_frame_buffer_core
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // x_first, y_first, x_second, y_second, pixel_value, angle, zero pad
    input  logic [rmfb_pkg::IN_DATA_W-1:0]    s_tdata,
    // cmd
    input  logic [rmfb_pkg::CMD_W-1:0]        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_read, column_select, blue_drive, red_drive, green_drive, zero pad
    output logic [rmfb_pkg::OUT_DATA_W-1:0]   m_tdata,
    // result_kind
    output logic                              m_tuser,
    output logic                              m_tlast
);

    rmfb_pkg::dp_cmd_t  dp_cmd;
    rmfb_pkg::dp_stat_t dp_stat;

    rmfb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

    rmfb_datapath u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .dp_cmd   (dp_cmd),
        .dp_stat  (dp_stat)
    );

endmodule

// ===== hdl/rmfb_checker.sv =====
// port-level checks on the frame buffer output stream, bound to the top level
`include "rgb_matrix_frame_buffer_core_macros.svh"

module rmfb_checker
(
    input logic                              clk,
    input logic                              rst_n,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [rmfb_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic                              m_tuser,
    input logic                              m_tlast
);

    `RMFB_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "output word changed while stalled")

    `RMFB_ASSERT_NOW(a_pixel_clean, clk, rst_n, m_tvalid && (m_tuser == rmfb_pkg::RESULT_PIXEL), (m_tdata[rmfb_pkg::OUT_DATA_W-1:4] == '0) && !m_tlast, "pixel word carries frame fields")

    `RMFB_ASSERT_NOW(a_frame_sel, clk, rst_n, m_tvalid && (m_tuser == rmfb_pkg::RESULT_FRAME), $onehot(m_tdata[11:4]) && (m_tdata[3:0] == 4'h0), "frame word column select not one-hot")

    `RMFB_ASSERT_NOW(a_last_col, clk, rst_n, m_tvalid && (m_tuser == rmfb_pkg::RESULT_FRAME), m_tlast == (m_tdata[11:4] == 8'h01), "last marker not on final column")

endmodule

bind rgb_matrix_frame_buffer_core rmfb_checker u_rmfb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
